// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files of the address range lookup block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define AST_ALWAYS(lbl, ck, rs, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rs) (cond)) \
        else $error("assertion failed");

// When ante holds, cons must hold in the same cycle.
`define AST_IMPL(lbl, ck, rs, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |-> (cons)) \
        else $error("assertion failed");

// When ante holds, cons must hold in the next cycle.
`define AST_NEXT(lbl, ck, rs, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/arflu_pkg.sv
// Package with the constants and types of the address range lookup block.
package arflu_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int HOST_W      = 64;
    localparam int GUEST_W     = 32;
    localparam int EXTENT_W    = 32;
    localparam int STATUS_W    = 2;

    localparam logic [EXTENT_W-1:0] EXTENT_RESET = EXTENT_W'(256 * 1024);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_LOOKUP = 1'b1
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 2'd0,
        ST_ZERO_FIELD = 2'd1,
        ST_FULL       = 2'd2
    } status_t;

    // Write control for one table cell.
    typedef struct packed {
        logic load_new;  // store the inserted pair here
        logic shift_in;  // take the pair of the cell below
    } cell_ctrl_t;

    // Result of one item as computed by the table.
    typedef struct packed {
        logic [GUEST_W-1:0] guest_function;
        logic               hit;
        status_t            status;
    } item_result_t;

endpackage

// File: rtl/core/arflu_cell.sv
// One entry of the sorted table: stored pair, address compare and range check.
module arflu_cell (
    input  logic                            clk,
    input  logic                            entry_valid,
    input  logic [arflu_pkg::HOST_W-1:0]    host,
    input  logic [arflu_pkg::GUEST_W-1:0]   guest,
    input  logic [arflu_pkg::EXTENT_W-1:0]  max_extent,
    input  logic [arflu_pkg::HOST_W-1:0]    prev_start,
    input  logic [arflu_pkg::GUEST_W-1:0]   prev_id,
    input  arflu_pkg::cell_ctrl_t           ctrl,
    output logic [arflu_pkg::HOST_W-1:0]    start,
    output logic [arflu_pkg::GUEST_W-1:0]   id,
    output logic                            not_above,
    output logic                            in_extent
);
    import arflu_pkg::*;

    logic [HOST_W-1:0]  start_reg;
    logic [GUEST_W-1:0] id_reg;
    logic [HOST_W-1:0]  offset;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_new)
        begin
            start_reg <= host;
            id_reg    <= guest;
        end
        else if (ctrl.shift_in)
        begin
            start_reg <= prev_start;
            id_reg    <= prev_id;
        end
    end

    assign offset    = host - start_reg;
    assign not_above = entry_valid && (start_reg <= host);
    assign in_extent = offset < {{(HOST_W - EXTENT_W){1'b0}}, max_extent};
    assign start     = start_reg;
    assign id        = id_reg;

endmodule

// File: rtl/core/arflu_table.sv
// Row of table cells with insertion control, fill tracking and lookup select.
`include "assert_macros.svh"

module arflu_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            commit,
    input  arflu_pkg::command_t             command,
    input  logic [arflu_pkg::HOST_W-1:0]    host,
    input  logic [arflu_pkg::GUEST_W-1:0]   guest,
    input  logic [arflu_pkg::EXTENT_W-1:0]  max_extent,
    output arflu_pkg::item_result_t         result
);
    import arflu_pkg::*;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;
    logic [TABLE_DEPTH-1:0] not_above;
    logic [TABLE_DEPTH-1:0] in_extent;
    logic [TABLE_DEPTH-1:0] match;
    logic [HOST_W-1:0]      start_q [TABLE_DEPTH];
    logic [GUEST_W-1:0]     id_q    [TABLE_DEPTH];
    cell_ctrl_t             ctrl    [TABLE_DEPTH];
    logic                   full;
    logic                   zero_field;
    logic                   do_insert;
    logic [GUEST_W-1:0]     sel_id;

    assign full       = valid_reg[TABLE_DEPTH-1];
    assign zero_field = (host == '0) || (guest == '0);
    assign do_insert  = commit && (command == CMD_INSERT) && !zero_field && !full;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            logic below_not_above;
            logic below_valid;
            logic above_not_above;

            if (gi == 0)
            begin : g_first
                assign below_not_above = 1'b1;
                assign below_valid     = 1'b0;
            end
            else
            begin : g_rest
                assign below_not_above = not_above[gi-1];
                assign below_valid     = valid_reg[gi-1];
            end

            if (gi == TABLE_DEPTH - 1)
            begin : g_last
                assign above_not_above = 1'b0;
            end
            else
            begin : g_mid
                assign above_not_above = not_above[gi+1];
            end

            // The insert position is the first cell that is empty or whose start lies
            // above the new address; the pairs stored from there upward move up one.
            assign ctrl[gi].load_new = do_insert && below_not_above && !not_above[gi];
            assign ctrl[gi].shift_in = do_insert && !below_not_above && below_valid;

            // The covering candidate is the last entry at or below the address.
            assign match[gi] = not_above[gi] && !above_not_above && in_extent[gi];

            arflu_cell u_cell (
                .clk         (clk),
                .entry_valid (valid_reg[gi]),
                .host        (host),
                .guest       (guest),
                .max_extent  (max_extent),
                .prev_start  ((gi == 0) ? start_q[0] : start_q[(gi == 0) ? 0 : gi-1]),
                .prev_id     ((gi == 0) ? id_q[0] : id_q[(gi == 0) ? 0 : gi-1]),
                .ctrl        (ctrl[gi]),
                .start       (start_q[gi]),
                .id          (id_q[gi]),
                .not_above   (not_above[gi]),
                .in_extent   (in_extent[gi])
            );
        end
    endgenerate

    always_comb
    begin
        sel_id = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            sel_id = sel_id | (id_q[i] & {GUEST_W{match[i]}});
        end
    end

    assign valid_next = do_insert ? {valid_reg[TABLE_DEPTH-2:0], 1'b1} : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        result.guest_function = '0;
        result.hit            = 1'b0;
        result.status         = ST_DONE;
        unique case (command)
            CMD_INSERT:
            begin
                priority if (zero_field)
                begin
                    result.status = ST_ZERO_FIELD;
                end
                else if (full)
                begin
                    result.status = ST_FULL;
                end
            end
            CMD_LOOKUP:
            begin
                result.hit            = |match;
                result.guest_function = sel_id;
            end
            default:
            begin
                result.status = ST_DONE;
            end
        endcase
    end

    // Filled entries always form a contiguous run from entry zero.
    `AST_ALWAYS(a_fill_contiguous, clk, rst_n, ((valid_reg >> 1) & ~valid_reg) == '0)
    // At most one entry can cover a looked-up address.
    `AST_ALWAYS(a_match_unique, clk, rst_n, $onehot0(match))
    // A full table stays full.
    `AST_NEXT(a_full_holds, clk, rst_n, full, valid_reg[TABLE_DEPTH-1])

endmodule

// File: rtl/core/address_range_function_lookup_top.sv
// Top level of the address range lookup block: channels, input and result registers.
//
// The block keeps a table of (host start address, guest function id) pairs
// sorted by host address and answers lookups of a program counter against it.
// Input beats (command, host_address, guest_address) arrive on item_valid /
// item_stall and each produces exactly one result beat (guest_function, hit,
// status) on result_valid / result_stall. A beat moves on a rising edge with
// valid high and stall low.
// Each beat is captured in an input register; from there every table cell
// compares its start against the address in parallel, the insert shifts the
// cells in place, and the answer lands in the result register. One beat is
// taken every cycle while item_stall is low, which is set by the single
// compare-and-select pass through the row of cells.
// When the receiver stalls, the result register holds, the input register
// holds its beat and item_stall rises once both are occupied, so no beat is
// lost or repeated. The max_extent register is written through cfg_valid /
// cfg_ready (always ready); the user must write it only while the block is
// idle, which the block itself does not enforce.
// Reset empties the table and sets max_extent to 256 KiB; no clearing pass is
// needed, so items are taken right after reset.
`include "assert_macros.svh"

module address_range_function_lookup_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic                            command,
    input  logic [arflu_pkg::HOST_W-1:0]    host_address,
    input  logic [arflu_pkg::GUEST_W-1:0]   guest_address,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [arflu_pkg::GUEST_W-1:0]   guest_function,
    output logic                            hit,
    output logic [arflu_pkg::STATUS_W-1:0]  status,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [arflu_pkg::EXTENT_W-1:0]  max_extent
);
    import arflu_pkg::*;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    command_t            s1_command_reg;
    logic [HOST_W-1:0]   s1_host_reg;
    logic [GUEST_W-1:0]  s1_guest_reg;
    logic                result_valid_reg;
    logic                result_valid_next;
    item_result_t        result_reg;
    item_result_t        table_result;
    logic [EXTENT_W-1:0] max_extent_reg;
    logic                advance;
    logic                accept;

    // The result register can take a new beat when it is empty or draining.
    assign advance    = !result_valid_reg || !result_stall;
    assign item_stall = s1_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    assign s1_valid_next     = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign result_valid_next = advance ? s1_valid_reg : result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            max_extent_reg   <= EXTENT_RESET;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                max_extent_reg <= max_extent;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_command_reg <= command_t'(command);
            s1_host_reg    <= host_address;
            s1_guest_reg   <= guest_address;
        end
        if (advance && s1_valid_reg)
        begin
            result_reg <= table_result;
        end
    end

    // The table updates on the same edge that captures the result, so the
    // next beat always sees the effect of this one.
    arflu_table u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .commit     (s1_valid_reg && advance),
        .command    (s1_command_reg),
        .host       (s1_host_reg),
        .guest      (s1_guest_reg),
        .max_extent (max_extent_reg),
        .result     (table_result)
    );

    assign result_valid   = result_valid_reg;
    assign guest_function = result_reg.guest_function;
    assign hit            = result_reg.hit;
    assign status         = result_reg.status;

    // A beat leaving the input register always lands in the result register.
    `AST_NEXT(a_beat_moves, clk, rst_n, s1_valid_reg && advance, result_valid_reg)
    // A hit is only ever reported with a done status.
    `AST_IMPL(a_hit_done, clk, rst_n, result_valid_reg && result_reg.hit,
              result_reg.status == ST_DONE)

endmodule

// File: tb/sv/tb_address_range_function_lookup_top.sv
// Self-checking testbench for the address range function lookup block.
`timescale 1ns / 100ps

module tb_address_range_function_lookup_top;
    import arflu_pkg::*;

    // One input beat as it is queued for the driver.
    typedef struct {
        command_t             cmd;
        logic [HOST_W-1:0]    host;
        logic [GUEST_W-1:0]   guest;
    } lookup_beat_t;

    // Time limit of the run, set far beyond its length even with heavy stalling.
    localparam int RUN_LIMIT_NS   = 5_000_000;
    localparam int HOLD_AT_RESULT = 400;
    localparam int HOLD_CYCLES    = 300;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    command_t               command = CMD_INSERT;
    logic [HOST_W-1:0]      host_address = '0;
    logic [GUEST_W-1:0]     guest_address = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic [GUEST_W-1:0]     guest_function;
    logic                   hit;
    logic [STATUS_W-1:0]    status;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [EXTENT_W-1:0]    max_extent = EXTENT_RESET;

    address_range_function_lookup_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .command        (command),
        .host_address   (host_address),
        .guest_address  (guest_address),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .guest_function (guest_function),
        .hit            (hit),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .max_extent     (max_extent)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow copy of the sorted table and of the extent register.
    logic [HOST_W-1:0]      shadow_start [TABLE_DEPTH];
    logic [GUEST_W-1:0]     shadow_id [TABLE_DEPTH];
    int                     shadow_count;
    logic [EXTENT_W-1:0]    shadow_extent;

    lookup_beat_t           queued_beats [$];
    item_result_t           expected_answers [$];
    logic [HOST_W-1:0]      known_starts [$];

    int                     mismatch_count = 0;
    int                     results_seen = 0;

    // Computes the answer to one accepted beat and applies an insert to the shadow table.
    // The upper bound search finds how many entries start at or below the address; that
    // is both the insert position (after equal starts) and one past the covering entry.
    task automatic resolve_beat(input command_t cmd, input logic [HOST_W-1:0] addr,
                                input logic [GUEST_W-1:0] gid, output item_result_t ans);
        int                 i;
        int                 upper;
        int                 k;
        logic [HOST_W-1:0]  reach;
        logic [HOST_W-1:0]  offset;
        logic [HOST_W-1:0]  gap;
        ans.guest_function = '0;
        ans.hit = 1'b0;
        ans.status = ST_DONE;
        upper = 0;
        for (i = 0; i < shadow_count; i++)
        begin
            if (shadow_start[i] <= addr)
                upper = i + 1;
        end
        if (cmd == CMD_INSERT)
        begin
            // The zero field check takes priority over the full check.
            if (addr == '0 || gid == '0)
                ans.status = ST_ZERO_FIELD;
            else if (shadow_count >= TABLE_DEPTH)
                ans.status = ST_FULL;
            else
            begin
                for (i = shadow_count; i > upper; i--)
                begin
                    shadow_start[i] = shadow_start[i-1];
                    shadow_id[i] = shadow_id[i-1];
                end
                shadow_start[upper] = addr;
                shadow_id[upper] = gid;
                shadow_count++;
            end
        end
        else if (upper > 0)
        begin
            k = upper - 1;
            reach = {{(HOST_W-EXTENT_W){1'b0}}, shadow_extent};
            // The difference never wraps since the start is at or below the address,
            // so an entry near the top of the space cannot cover low addresses.
            offset = addr - shadow_start[k];
            if (k + 1 < shadow_count)
            begin
                gap = shadow_start[k+1] - shadow_start[k];
                if (gap < reach)
                    reach = gap;
            end
            if (offset < reach)
            begin
                ans.guest_function = shadow_id[k];
                ans.hit = 1'b1;
            end
        end
    endtask

    // Sender: bursts of random length separated by random gaps. A beat that is
    // stalled keeps its valid and payload until it is taken.
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        item_result_t ans;
        lookup_beat_t nxt;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            command <= CMD_INSERT;
            host_address <= '0;
            guest_address <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                resolve_beat(command, host_address, guest_address, ans);
                expected_answers = {expected_answers, ans};
            end
            if (!item_valid || !item_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (queued_beats.size() != 0)
                begin
                    nxt = queued_beats.pop_front();
                    command <= nxt.cmd;
                    host_address <= nxt.host;
                    guest_address <= nxt.guest;
                    item_valid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else if ($urandom_range(0, 3) == 0)
                    begin
                        // A long stretch with no idling at all.
                        burst_left = $urandom_range(20, 60);
                        gap_left = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = $urandom_range(0, 7);
                    end
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Receiver: a stall pattern that changes mode after stretches of random length, and one long
    // hold-off that lets the block fill up and push back on the sender.
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        item_result_t want;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (expected_answers.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result beat: guest %h hit %b status %0d",
                                 guest_function, hit, status);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (guest_function !== want.guest_function || hit !== want.hit ||
                        status !== want.status)
                    begin
                        if (mismatch_count < 10)
                            $display("result %0d mismatch: guest %h/%h hit %b/%b status %0d/%0d",
                                     results_seen, guest_function, want.guest_function,
                                     hit, want.hit, status, want.status);
                        mismatch_count++;
                    end
                end
            end

            if (!hold_done && results_seen >= HOLD_AT_RESULT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end

            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (stall_mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 3) == 0);
                    2: result_stall <= ($urandom_range(0, 3) != 0);
                    default: result_stall <= mode_left[0];
                endcase
            end
        end
    end

    task automatic queue_beat(input command_t cmd, input logic [HOST_W-1:0] addr,
                              input logic [GUEST_W-1:0] gid);
        lookup_beat_t b;
        b.cmd = cmd;
        b.host = addr;
        b.guest = gid;
        queued_beats = {queued_beats, b};
        if (cmd == CMD_INSERT && addr != '0 && gid != '0)
            known_starts = {known_starts, addr};
    endtask

    // Waits until every queued beat was taken and answered, then lets the pipe settle.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (queued_beats.size() != 0 || item_valid || expected_answers.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_extent(input logic [EXTENT_W-1:0] value);
        wait_drained();
        @(posedge clk);
        cfg_valid <= 1'b1;
        max_extent <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        shadow_extent = value;
    endtask

    // Random beats. Most lookups land near a known start or on the edges of the extent,
    // so that hits and misses both occur often.
    task automatic queue_random(input int count, input int insert_pct,
                                input logic [EXTENT_W-1:0] ext);
        int                 n;
        logic [HOST_W-1:0]  addr;
        logic [HOST_W-1:0]  base;
        logic [GUEST_W-1:0] gid;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < insert_pct)
            begin
                gid = $urandom;
                case ($urandom_range(0, 9))
                    0, 1, 2:
                        addr = 64'h0000_0000_0040_0000 + ($urandom_range(0, 32'h7FFFF) & ~3);
                    3:
                        addr = 64'h0000_7FFF_0000_0000 + ($urandom_range(0, 32'h7FFFF) & ~3);
                    4:
                        addr = 64'hFFFF_FFFF_FFF0_0000 + $urandom_range(0, 32'hFFFFF);
                    5, 6:
                        addr = (known_starts.size() != 0) ?
                               known_starts[$urandom_range(0, known_starts.size() - 1)] :
                               {$urandom, $urandom};
                    7:
                        addr = {$urandom, $urandom};
                    8:
                        addr = '0;
                    default:
                    begin
                        addr = {$urandom, $urandom};
                        gid = '0;
                    end
                endcase
                queue_beat(CMD_INSERT, addr, gid);
            end
            else
            begin
                if (known_starts.size() != 0 && $urandom_range(0, 9) < 7)
                begin
                    base = known_starts[$urandom_range(0, known_starts.size() - 1)];
                    case ($urandom_range(0, 7))
                        0: addr = base;
                        1: addr = base - 1;
                        2: addr = base + 1;
                        3: addr = base + ext - 1;
                        4: addr = base + ext;
                        5: addr = base + $urandom_range(0, 255);
                        6: addr = base - $urandom_range(0, 255);
                        default: addr = base + $urandom_range(0, 32'h80000);
                    endcase
                end
                else if ($urandom_range(0, 2) != 0)
                    addr = {$urandom, $urandom};
                else
                    addr = $urandom_range(0, 1) ? '1 : '0;
                queue_beat(CMD_LOOKUP, addr, $urandom);
            end
        end
    endtask

    initial
    begin
        #RUN_LIMIT_NS;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        shadow_count = 0;
        shadow_extent = EXTENT_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats under the reset extent: empty table, zero fields, the extent
        // edge, equal starts, the gap limit and entries near the top of the space.
        queue_beat(CMD_LOOKUP, 64'h0, 32'hFFFF_FFFF);
        queue_beat(CMD_LOOKUP, '1, 32'h0);
        queue_beat(CMD_INSERT, 64'h0, 32'h5);
        queue_beat(CMD_INSERT, 64'h1000, 32'h0);
        queue_beat(CMD_INSERT, 64'h0, 32'h0);
        queue_beat(CMD_INSERT, 64'h1000, 32'hA);
        queue_beat(CMD_LOOKUP, 64'h1000, 32'h0);
        queue_beat(CMD_LOOKUP, 64'h0FFF, 32'h0);
        queue_beat(CMD_LOOKUP, 64'h1000 + 64'h3FFFF, 32'h0);
        queue_beat(CMD_LOOKUP, 64'h1000 + 64'h40000, 32'h0);
        queue_beat(CMD_INSERT, 64'h1000, 32'hB);
        queue_beat(CMD_LOOKUP, 64'h1000, 32'h0);
        queue_beat(CMD_INSERT, 64'h2000, 32'hC);
        queue_beat(CMD_LOOKUP, 64'h1FFF, 32'h0);
        queue_beat(CMD_LOOKUP, 64'h2000, 32'h0);
        queue_beat(CMD_INSERT, 64'hFFFF_FFFF_FFFF_F000, 32'hFFFF_FFFF);
        queue_beat(CMD_LOOKUP, '1, 32'h0);
        queue_beat(CMD_LOOKUP, 64'h0, 32'h0);
        queue_beat(CMD_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000);
        queue_beat(CMD_LOOKUP, 64'h8000_0000_0003_FFFF, 32'h0);

        // The table fills during the first two phases and stays full afterwards, so
        // later inserts check the full and zero field cases under every extent.
        queue_random(180, 30, EXTENT_RESET);
        write_extent(32'd1);
        queue_random(180, 20, 32'd1);
        write_extent(32'hFFFF_FFFF);
        queue_random(180, 15, 32'hFFFF_FFFF);
        write_extent(32'h100);
        queue_random(180, 10, 32'h100);
        begin
            logic [EXTENT_W-1:0] any_extent;
            any_extent = $urandom;
            write_extent(any_extent);
            queue_random(180, 10, any_extent);
        end
        // Zero extent: nothing is covered and every lookup misses.
        write_extent(32'd0);
        queue_random(180, 10, 32'd0);
        write_extent(32'h1000);
        queue_random(180, 10, 32'h1000);
        write_extent(EXTENT_RESET);
        queue_random(180, 10, EXTENT_RESET);

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_answers.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
